// File: rtl/fcsc_pkg.sv
// Shared constants and types for the frame change similarity curve core.
package fcsc_pkg;

  // Frame geometry
  localparam int MAX_DIM = 64;
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W   = 7;
  localparam int CMP_W   = (DIM_W > IDX_W + 1) ? DIM_W : IDX_W + 1;

  // Datapath widths
  localparam int FEAT_W  = 16;
  localparam int SQ_W    = 2 * FEAT_W;
  localparam int SUM_W   = 38;

  // Similarity divider: floor(2^40 / (2^24 + D))
  localparam int NUM_EXP = 40;
  localparam int ONE_EXP = 24;
  localparam int QUO_W   = 17;
  localparam int DEN_W   = SUM_W + 1;
  localparam int REM_W   = DEN_W + 1;
  localparam int STEP_W  = $clog2(QUO_W);

  // Frame queue between the front and the back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  // Result stream
  localparam int OUT_TDATA_W = ((SUM_W + 7) / 8) * 8;
  localparam logic KIND_SIM  = 1'b0;
  localparam logic KIND_NORM = 1'b1;

  // One finished frame handed from the accumulator to the divider
  typedef struct packed {
    logic [SUM_W-1:0] dist_total;
    logic [SUM_W-1:0] norm;
    logic             fin;
  } fcsc_frame_t;

endpackage

// File: rtl/fcsc_front.sv
// Front part: element intake, previous-frame memory, squaring and frame accumulation.
module fcsc_front import fcsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [DIM_W-1:0]  cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [FEAT_W-1:0] in_tdata,
  input  logic              in_tlast,
  input  logic [QCNT_W-1:0] q_count,
  output logic              q_push,
  output fcsc_frame_t       q_data
);

  // Configuration and element position
  logic [DIM_W-1:0]   feat_dim_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [MAX_DIM-1:0] valid_r, valid_nxt;
  logic [CMP_W-1:0]   fd_ext, dim, pos;
  logic               accept, fend;

  // Stage 1: element and previous value
  logic              s1_vld_r;
  logic [FEAT_W-1:0] s1_x_r, s1_prev_r;
  logic              s1_pv_r, s1_end_r, s1_fin_r;
  logic [FEAT_W-1:0] prev_mem [MAX_DIM];

  // Stage 2: squared terms
  logic              s2_vld_r;
  logic [SQ_W-1:0]   s2_sqd_r, s2_sqn_r;
  logic              s2_end_r, s2_fin_r;
  logic signed [FEAT_W+1:0] x_ext, p_ext, diff, x_abs, d_abs;
  logic [FEAT_W-1:0] adiff, ax;

  // Stage 3: running sums
  logic [SUM_W-1:0]  dist_r, dist_nxt, norm_r, norm_nxt, dsat, nsat;
  logic [SUM_W:0]    dsum, nsum;
  logic [QCNT_W:0]   pending;

  // Room check: every frame end still in flight needs a queue slot
  assign pending = {1'b0, q_count} + (QCNT_W+1)'(s1_vld_r & s1_end_r)
                 + (QCNT_W+1)'(s2_vld_r & s2_end_r);
  assign in_tready = (pending < (QCNT_W+1)'(QDEPTH));
  assign accept = in_tvalid & in_tready;

  // Active dimension with out-of-range values clamped
  always_comb begin
    fd_ext = CMP_W'(feat_dim_r);
    if (fd_ext == '0) begin
      dim = CMP_W'(1);
    end else if (fd_ext > CMP_W'(MAX_DIM)) begin
      dim = CMP_W'(MAX_DIM);
    end else begin
      dim = fd_ext;
    end
    pos  = CMP_W'(idx_r) + CMP_W'(1);
    fend = (pos >= dim);
  end

  // Next index and previous-frame valid bits
  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (accept) begin
      if (fend) begin
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
      end
      if (fend && in_tlast) begin
        valid_nxt = '0;
      end else begin
        valid_nxt = valid_r | (MAX_DIM'(1) << idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feat_dim_r <= DIM_W'(1);
      idx_r      <= '0;
      valid_r    <= '0;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      dist_r     <= '0;
      norm_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        feat_dim_r <= cfg_wr_data;
      end
      idx_r    <= idx_nxt;
      valid_r  <= valid_nxt;
      s1_vld_r <= accept;
      s2_vld_r <= s1_vld_r;
      dist_r   <= dist_nxt;
      norm_r   <= norm_nxt;
    end
  end

  // Previous-frame memory: read-first, one port, same address
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_mem[idx_r] <= in_tdata;
      s1_prev_r       <= prev_mem[idx_r];
      s1_x_r          <= in_tdata;
      s1_pv_r         <= valid_r[idx_r];
      s1_end_r        <= fend;
      s1_fin_r        <= in_tlast;
    end
  end

  // Difference and magnitudes; entries never written this sequence read as zero.
  // The difference of two elements spans twice the element range, so two guard bits.
  always_comb begin
    x_ext = {{2{s1_x_r[FEAT_W-1]}}, s1_x_r};
    p_ext = s1_pv_r ? {{2{s1_prev_r[FEAT_W-1]}}, s1_prev_r} : '0;
    diff  = x_ext - p_ext;
    d_abs = diff[FEAT_W+1] ? -diff : diff;
    x_abs = x_ext[FEAT_W+1] ? -x_ext : x_ext;
    adiff = d_abs[FEAT_W-1:0];
    ax    = x_abs[FEAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    s2_sqd_r <= adiff * adiff;
    s2_sqn_r <= ax * ax;
    s2_end_r <= s1_end_r;
    s2_fin_r <= s1_fin_r;
  end

  // Saturating accumulation and hand-off at frame end
  always_comb begin
    dsum     = {1'b0, dist_r} + (SUM_W+1)'(s2_sqd_r);
    nsum     = {1'b0, norm_r} + (SUM_W+1)'(s2_sqn_r);
    dsat     = dsum[SUM_W] ? '1 : dsum[SUM_W-1:0];
    nsat     = nsum[SUM_W] ? '1 : nsum[SUM_W-1:0];
    dist_nxt = dist_r;
    norm_nxt = norm_r;
    if (s2_vld_r) begin
      dist_nxt = s2_end_r ? '0 : dsat;
      norm_nxt = s2_end_r ? '0 : nsat;
    end
    q_push            = s2_vld_r & s2_end_r;
    q_data.dist_total = dsat;
    q_data.norm       = nsat;
    q_data.fin        = s2_fin_r;
  end

`ifndef SYNTHESIS
  a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fend) |=> (idx_r == '0))
    else $error("element index did not restart after frame end");

  a_seq_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fend && in_tlast) |=> (valid_r == '0))
    else $error("previous frame not cleared after final frame");

  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_count < QCNT_W'(QDEPTH)))
    else $error("frame pushed without queue room");
`endif

endmodule

// File: rtl/fcsc_queue.sv
// Small FIFO of finished frame sums between the accumulator and the divider.
module fcsc_queue import fcsc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fcsc_frame_t       push_data,
  input  logic              pop,
  output logic              q_valid,
  output fcsc_frame_t       q_data,
  output logic [QCNT_W-1:0] q_count
);

  fcsc_frame_t       slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign q_valid = (count_r != '0);
  assign q_data  = slots[rd_ptr_r];
  assign q_count = count_r;

  // Occupancy update
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (count_r != QCNT_W'(QDEPTH)))
    else $error("frame queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("frame queue underflow");

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (QPTR_W'(wr_ptr_r - rd_ptr_r) == count_r[QPTR_W-1:0]))
    else $error("queue pointers disagree with count");
`endif

endmodule

// File: rtl/fcsc_back.sv
// Back part: restoring divider for the similarity and the result output register.
module fcsc_back import fcsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  fcsc_frame_t            q_data,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SIM  = 4'b0100,
    ST_NORM = 4'b1000
  } back_state_t;

  localparam logic [DEN_W-1:0] ONE_Q24  = DEN_W'(1) << ONE_EXP;
  localparam logic [REM_W-1:0] REM_INIT = REM_W'(1) << (NUM_EXP - QUO_W);

  back_state_t       state_r, state_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [REM_W-1:0]  rem_r, rem2, rem_nxt;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  norm_r;
  logic              fin_r;
  logic              ge;

  logic              out_vld_r, out_free, load_sim, load_norm;
  logic [SUM_W-1:0]  out_val_r;
  logic              out_kind_r, out_last_r;

  assign out_free  = !out_vld_r || out_tready;
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign load_sim  = (state_r == ST_SIM) && out_free;
  assign load_norm = (state_r == ST_NORM) && out_free;

  // One quotient bit per step
  always_comb begin
    rem2    = {rem_r[REM_W-2:0], 1'b0};
    ge      = (rem2 >= REM_W'(den_r));
    rem_nxt = ge ? (rem2 - REM_W'(den_r)) : rem2;
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (step_r == '0) begin
          state_nxt = ST_SIM;
        end
      end
      ST_SIM: begin
        if (out_free) begin
          state_nxt = fin_r ? ST_NORM : ST_IDLE;
        end
      end
      ST_NORM: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_sim || load_norm) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Divider operands and iteration
  always_ff @(posedge clk) begin
    if (q_pop) begin
      den_r  <= {1'b0, q_data.dist_total} + ONE_Q24;
      rem_r  <= REM_INIT;
      quo_r  <= '0;
      step_r <= STEP_W'(QUO_W - 1);
      norm_r <= q_data.norm;
      fin_r  <= q_data.fin;
    end else if (state_r == ST_DIV) begin
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[QUO_W-2:0], ge};
      step_r <= step_r - STEP_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_sim) begin
      out_val_r  <= SUM_W'(quo_r);
      out_kind_r <= KIND_SIM;
      out_last_r <= !fin_r;
    end else if (load_norm) begin
      out_val_r  <= norm_r;
      out_kind_r <= KIND_NORM;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'(out_val_r);
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_norm_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (load_sim && fin_r) |=> (state_r == ST_NORM))
    else $error("final frame norm not scheduled after similarity");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < REM_W'(den_r)))
    else $error("divider remainder out of range");

  a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_kind_r == KIND_SIM)) |-> (out_val_r[SUM_W-1:QUO_W] == '0))
    else $error("similarity exceeds one");
`endif

endmodule

// File: rtl/frame_change_similarity_curve_core.sv
// Top level of the frame change similarity curve core.
// Feature elements (signed Q3.12) are taken one per cycle as long as the frame queue
// has room; each frame end is queued with its squared distance to the previous frame
// and its squared norm. The back end turns each queued frame into 1/(1+d) in Q1.16 with
// a restoring divider: it pops the frame from the queue, computes the 17 quotient bits
// one per step, and then loads the result; a final frame also emits its squared norm in
// Q.24 as a second item, kind 1, with tlast. The back end pops the next frame only once
// the current one's results are loaded, so short frames are limited by the divider once
// the four-entry queue fills. The similarity item of a frame passes the stage 1 and
// stage 2 registers, the queue, the divider and the output register. The previous frame
// lives in a 64-entry memory whose entries carry valid bits, so no clearing pass is
// needed after reset or between sequences.
module frame_change_similarity_curve_core import fcsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [DIM_W-1:0]       cfg_wr_data,   // feat_dim
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [FEAT_W-1:0]      in_tdata,      // feature_value
  input  logic                   in_tlast,      // last_frame
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,     // result_value, zero padded
  output logic                   out_tuser,     // result_kind
  output logic                   out_tlast      // last_result
);

  logic              q_push, q_pop, q_valid;
  fcsc_frame_t       push_data, pop_data;
  logic [QCNT_W-1:0] q_count;

  fcsc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .q_count     (q_count),
    .q_push      (q_push),
    .q_data      (push_data)
  );

  fcsc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .q_count   (q_count)
  );

  fcsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (pop_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
